// File: rtl/sts_pkg.sv
package sts_pkg;

  localparam int TERMS     = 6;
  localparam int MAX_TERMS = 6;
  localparam int TOP_TERMS = (TERMS < 1) ? 1 : ((TERMS > MAX_TERMS) ? MAX_TERMS : TERMS);
  localparam int HORNER_CELLS = TOP_TERMS - 1;

  localparam int ANGLE_W = 16;
  localparam int SINE_W  = 16;
  localparam int SQ_W    = 31;
  localparam int ACC_W   = 32;
  localparam int PROD_W  = 2 * ACC_W;
  localparam int SCL_W   = ACC_W + ANGLE_W;
  localparam int Y_FRAC  = 26;
  localparam int S_SHIFT = 27;
  localparam int S_W     = SCL_W - S_SHIFT;

  localparam logic signed [SINE_W-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [ACC_W-1:0] acc_t;

  // (-1)^i * round(2^28 / (2i+1)!)
  localparam acc_t COEF_Q28 [MAX_TERMS] = '{
    32'sd268435456, -32'sd44739243, 32'sd2236962, -32'sd53261, 32'sd740, -32'sd7
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] x;
    logic [SQ_W-1:0]           y;
    acc_t                      p;
  } stage_t;

endpackage

// File: rtl/sts_angle_if.sv
interface sts_angle_if;
  import sts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);

endinterface

// File: rtl/sts_sine_if.sv
interface sts_sine_if;
  import sts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SINE_W-1:0] sine_value;

  modport source (output valid, output sine_value, input ready);
  modport sink   (input valid, input sine_value, output ready);

endinterface

// File: rtl/sts_square.sv
module sts_square import sts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output stage_t                    stage_o
);

  logic                        valid_q;
  stage_t                      stage_q, stage_d;
  logic signed [2*ANGLE_W-1:0] sq;

  assign ready_o = !valid_q || ready_i;
  assign sq      = (2*ANGLE_W)'(angle_i) * (2*ANGLE_W)'(angle_i);

  always_comb begin
    stage_d.x = angle_i;
    stage_d.y = sq[SQ_W-1:0];
    stage_d.p = COEF_Q28[TOP_TERMS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

  a_sq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(stage_q))
    else $error("square cell lost its item under stall");

endmodule

// File: rtl/sts_horner_cell.sv
module sts_horner_cell import sts_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  acc_t   coef_i,
  input  logic   valid_i,
  output logic   ready_o,
  input  stage_t stage_i,
  output logic   valid_o,
  input  logic   ready_i,
  output stage_t stage_o
);

  logic                     valid_q;
  stage_t                   stage_q, stage_d;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;

  assign ready_o = !valid_q || ready_i;

  // p = c + rnd(p*y, 26)
  assign prod = PROD_W'(stage_i.p) * PROD_W'($signed({1'b0, stage_i.y}));
  assign rnd  = prod + (PROD_W'(1) <<< (Y_FRAC - 1));

  always_comb begin
    stage_d   = stage_i;
    stage_d.p = coef_i + $signed(rnd[Y_FRAC +: ACC_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(stage_q))
    else $error("horner cell lost its item under stall");

endmodule

// File: rtl/sts_scale.sv
module sts_scale import sts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  stage_t                   stage_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [SINE_W-1:0] sine_o
);

  logic                     valid_q;
  logic signed [SINE_W-1:0] sine_q, sine_d;
  logic signed [SCL_W-1:0]  prod;
  logic signed [SCL_W-1:0]  rnd;
  logic signed [S_W-1:0]    s;

  assign ready_o = !valid_q || ready_i;

  // s = rnd(p*x, 27), clamped to +/- one
  assign prod = SCL_W'(stage_i.p) * SCL_W'(stage_i.x);
  assign rnd  = prod + (SCL_W'(1) <<< (S_SHIFT - 1));
  assign s    = rnd[SCL_W-1:S_SHIFT];

  always_comb begin
    if (s > S_W'(ONE_Q14)) begin
      sine_d = ONE_Q14;
    end else if (s < -S_W'(ONE_Q14)) begin
      sine_d = -ONE_Q14;
    end else begin
      sine_d = s[SINE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sine_q <= sine_d;
    end
  end

  assign valid_o = valid_q;
  assign sine_o  = sine_q;

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (sine_q <= ONE_Q14) && (sine_q >= -ONE_Q14))
    else $error("sine outside saturation range");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && (stage_i.x == '0) |=> valid_q && (sine_q == '0))
    else $error("zero angle gave non-zero sine");

endmodule

// File: rtl/sine_taylor_series.sv
// Sine of a Q3.13 angle by truncated Maclaurin series, result in Q2.14.
//
// Channels: angle_i takes one item (angle) per valid/ready handshake;
// sine_o returns one item (sine_value) per angle, in order.
// The series is TERMS terms long, evaluated in Horner form over x^2 by a
// row of identical cells, each doing one multiply and add per item, then
// scaled by x, rounded and clamped to +/- one.
//
// Pipeline: one register to square, one per Horner cell, one to scale
// and clamp, between the accept of an angle and the offer of its sine.
// Throughput: one item per cycle unless the receiver stalls; each cell
// is a pipeline register.
//
// Reset clears every stage valid; no item is in flight afterwards.
// When the receiver stalls, items back up stage by stage; angle_i.ready
// stays high while any stage is empty, and drops once the row is full.
module sine_taylor_series import sts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sts_angle_if.sink   angle_i,
  sts_sine_if.source  sine_o
);

  stage_t stg [HORNER_CELLS+1];
  logic   vld [HORNER_CELLS+1];
  logic   rdy [HORNER_CELLS+1];

  sts_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (angle_i.valid),
    .ready_o (angle_i.ready),
    .angle_i (angle_i.angle),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .stage_o (stg[0])
  );

  for (genvar k = 0; k < HORNER_CELLS; k++) begin : g_cell
    sts_horner_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_i  (COEF_Q28[HORNER_CELLS-1-k]),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .stage_i (stg[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .stage_o (stg[k+1])
    );
  end

  sts_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[HORNER_CELLS]),
    .ready_o (rdy[HORNER_CELLS]),
    .stage_i (stg[HORNER_CELLS]),
    .valid_o (sine_o.valid),
    .ready_i (sine_o.ready),
    .sine_o  (sine_o.sine_value)
  );

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sine_o.ready |-> angle_i.ready)
    else $error("input blocked while output drains");

endmodule
